FILE: sv/fourier_shell_mask_defines.svh
// Assertion macros used by the checker file of the shell mask block.
`ifndef FOURIER_SHELL_MASK_DEFINES_SVH
`define FOURIER_SHELL_MASK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSHM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSHM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fshm_pkg.sv
// Types and constants shared by the shell mask block.
package fshm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IDX_W     = 10;
    localparam int GS_W      = 11;
    localparam int MAG_W     = GS_W;
    localparam int RAD_W     = 18;
    localparam int HW_W      = 16;
    localparam int CFG_W     = 18;
    localparam int CIDX_W    = 3;
    localparam int OUT_W     = 40;
    localparam int CMAG_W    = MAG_W + FRAC_BITS + 1;
    localparam int CSQ_W     = 2 * CMAG_W;
    localparam int PSUM_W    = CSQ_W + 2;
    localparam int MSQ_W     = 2 * MAG_W;
    localparam int MSUM_W    = MSQ_W + 2;
    localparam int M2_W      = MSUM_W + 2 * FRAC_BITS;
    localparam int BND_W     = RAD_W + 1;
    localparam int BSQ_W     = 2 * BND_W;
    localparam int CMP_W     = (M2_W > PSUM_W) ? M2_W : PSUM_W;

    localparam logic [GS_W-1:0] GRID_RESET = GS_W'(256);
    localparam logic [HW_W-1:0] HW_RESET   = HW_W'(128);

    typedef enum logic [1:0] {
        MODE_CENTERED,
        MODE_BOUNDS,
        MODE_CORNER,
        MODE_OVERLAP
    } t_mode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MODE,
        CFG_GRID_SIZE,
        CFG_SLAB_START,
        CFG_SHELL_CENTER,
        CFG_HALF_WIDTH,
        CFG_LOW_BOUND,
        CFG_HIGH_BOUND
    } t_cfg_index;

    typedef struct packed {
        t_mode             mode;
        logic [GS_W-1:0]   grid_size;
        logic [IDX_W-1:0]  slab_start;
        logic [RAD_W-1:0]  shell_center;
        logic [HW_W-1:0]   half_width;
        logic [RAD_W-1:0]  low_bound;
        logic [RAD_W-1:0]  high_bound;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] x_local;
        logic [IDX_W-1:0] y_index;
        logic [IDX_W-1:0] z_index;
        logic             restart;
    } t_in_item;

    typedef struct packed {
        logic             in_shell;
        logic [OUT_W-1:0] min_corner_sq;
        logic [OUT_W-1:0] max_corner_sq;
    } t_out_item;

    // One axis after wrapping: frequency magnitude and corner magnitudes.
    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [CMAG_W-1:0] clo;
        logic [CMAG_W-1:0] chi;
    } t_axis;

    typedef struct packed {
        t_axis [2:0] ax;
        logic        restart;
    } t_stage1;

    typedef struct packed {
        logic [2:0][MSQ_W-1:0] msq;
        logic [2:0][CSQ_W-1:0] plo;
        logic [2:0][CSQ_W-1:0] phi;
        logic [BSQ_W-1:0]      bsq_a;
        logic [BSQ_W-1:0]      bsq_b;
        logic                  a_pos;
        logic                  restart;
    } t_stage2;

endpackage

FILE: sv/fourier_shell_mask.sv
// Top level of the k-space spherical shell mask: config, pipeline and handshakes.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | request   | i_in_valid / o_in_ready   | i_in_data  (x, y, z, restart)
//   out     | result    | o_out_valid / i_out_ready | o_out_data (in_shell, min, max)
//   cfg     | write     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_ready is high; each result passes through r_s1, r_s2 and r_out.
// The pipeline is wrap and corner magnitudes, then squares, then sums, tests and tracking.
// Each stage moves when the stage after it is empty or moving, so bubbles are squeezed out.
// Reset (synchronous, active low) restores register defaults and empties the pipeline.
// Configuration writes are always taken; o_cfg_ready is tied high.
module fourier_shell_mask (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fshm_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fshm_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fshm_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [fshm_pkg::CFG_W-1:0]  i_cfg_data
);
    import fshm_pkg::*;

    t_cfg      r_cfg;
    logic      r_s1_valid;
    t_stage1   r_s1;
    t_stage1   n_s1;
    logic      r_s2_valid;
    t_stage2   r_s2;
    t_stage2   n_s2;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic w_rdy_o;
    logic w_rdy2;
    logic w_rdy1;
    logic w_take;

    logic [GS_W-1:0]  w_gx;
    logic [BND_W-1:0] w_h_ext;
    logic [BND_W-1:0] w_diff;
    logic [BND_W-1:0] w_a;
    logic [BND_W-1:0] w_b;
    logic             w_a_pos;
    logic             w_sel;
    logic [OUT_W-1:0] w_smin;
    logic [OUT_W-1:0] w_smax;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_CENTERED;
            r_cfg.grid_size    <= GRID_RESET;
            r_cfg.slab_start   <= '0;
            r_cfg.shell_center <= '0;
            r_cfg.half_width   <= HW_RESET;
            r_cfg.low_bound    <= '0;
            r_cfg.high_bound   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:         r_cfg.mode         <= t_mode'(i_cfg_data[1:0]);
                CFG_GRID_SIZE:    r_cfg.grid_size    <= i_cfg_data[GS_W-1:0];
                CFG_SLAB_START:   r_cfg.slab_start   <= i_cfg_data[IDX_W-1:0];
                CFG_SHELL_CENTER: r_cfg.shell_center <= i_cfg_data[RAD_W-1:0];
                CFG_HALF_WIDTH:   r_cfg.half_width   <= i_cfg_data[HW_W-1:0];
                CFG_LOW_BOUND:    r_cfg.low_bound    <= i_cfg_data[RAD_W-1:0];
                CFG_HIGH_BOUND:   r_cfg.high_bound   <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign w_rdy_o    = !r_out_valid || i_out_ready;
    assign w_rdy2     = !r_s2_valid || w_rdy_o;
    assign w_rdy1     = !r_s1_valid || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_take     = w_rdy_o && r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy_o) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // ---------------- stage 1: wrap and corner magnitudes ----------------
    assign w_gx = {1'b0, i_in_data.x_local} + {1'b0, r_cfg.slab_start};

    fshm_axis u_axis_x (
        .i_gidx       (w_gx),
        .i_grid_size  (r_cfg.grid_size),
        .i_half_width (r_cfg.half_width),
        .o_axis       (n_s1.ax[0])
    );

    fshm_axis u_axis_y (
        .i_gidx       ({1'b0, i_in_data.y_index}),
        .i_grid_size  (r_cfg.grid_size),
        .i_half_width (r_cfg.half_width),
        .o_axis       (n_s1.ax[1])
    );

    fshm_axis u_axis_z (
        .i_gidx       ({1'b0, i_in_data.z_index}),
        .i_grid_size  (r_cfg.grid_size),
        .i_half_width (r_cfg.half_width),
        .o_axis       (n_s1.ax[2])
    );

    assign n_s1.restart = i_in_data.restart;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 2: squares ----------------
    // Shell bounds per mode: operand a is the lower bound, b the upper one.
    assign w_h_ext = {{(BND_W-HW_W){1'b0}}, r_cfg.half_width};

    always_comb begin
        w_diff  = '0;
        w_a     = '0;
        w_b     = '0;
        w_a_pos = 1'b1;
        case (r_cfg.mode)
            MODE_CENTERED: begin
                w_diff  = {1'b0, r_cfg.shell_center} - w_h_ext;
                w_b     = {1'b0, r_cfg.shell_center} + w_h_ext;
                w_a_pos = !w_diff[BND_W-1] && (w_diff != '0);
                w_a     = w_a_pos ? w_diff : '0;
            end
            MODE_BOUNDS: begin
                w_diff  = {1'b0, r_cfg.low_bound} - w_h_ext;
                w_b     = {1'b0, r_cfg.high_bound} + w_h_ext;
                w_a_pos = !w_diff[BND_W-1] && (w_diff != '0);
                w_a     = w_a_pos ? w_diff : '0;
            end
            MODE_CORNER: begin
                w_a = {1'b0, r_cfg.shell_center};
                w_b = {1'b0, r_cfg.shell_center};
            end
            MODE_OVERLAP: begin
                w_a = {1'b0, r_cfg.low_bound};
                w_b = {1'b0, r_cfg.high_bound};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2.msq[k] = MSQ_W'(r_s1.ax[k].mag) * MSQ_W'(r_s1.ax[k].mag);
            n_s2.plo[k] = CSQ_W'(r_s1.ax[k].clo) * CSQ_W'(r_s1.ax[k].clo);
            n_s2.phi[k] = CSQ_W'(r_s1.ax[k].chi) * CSQ_W'(r_s1.ax[k].chi);
        end
        n_s2.bsq_a   = BSQ_W'(w_a) * BSQ_W'(w_a);
        n_s2.bsq_b   = BSQ_W'(w_b) * BSQ_W'(w_b);
        n_s2.a_pos   = w_a_pos;
        n_s2.restart = r_s1.restart;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- stage 3: tests, tracking, result register ----------------
    fshm_decide u_decide (
        .i_s2   (r_s2),
        .i_mode (r_cfg.mode),
        .o_sel  (w_sel),
        .o_smin (w_smin),
        .o_smax (w_smax)
    );

    fshm_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_restart (r_s2.restart),
        .i_sel     (w_sel),
        .i_smin    (w_smin),
        .i_smax    (w_smax),
        .o_min     (n_out.min_corner_sq),
        .o_max     (n_out.max_corner_sq)
    );

    assign n_out.in_shell = w_sel;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/fshm_axis.sv
// Index wrap and per-axis corner magnitudes for one grid axis.
module fshm_axis (
    input  logic [fshm_pkg::GS_W-1:0] i_gidx,
    input  logic [fshm_pkg::GS_W-1:0] i_grid_size,
    input  logic [fshm_pkg::HW_W-1:0] i_half_width,
    output fshm_pkg::t_axis           o_axis
);
    import fshm_pkg::*;

    logic [GS_W-1:0]   w_half;
    logic              w_wrap;
    logic [GS_W:0]     w_diff;
    logic [GS_W:0]     w_neg;
    logic [MAG_W-1:0]  w_mag;
    logic [CMAG_W-1:0] w_s;
    logic [CMAG_W-1:0] w_h;

    assign w_half = i_grid_size >> 1;
    assign w_wrap = i_gidx >= w_half;
    assign w_diff = {1'b0, i_gidx} - {1'b0, i_grid_size};
    assign w_neg  = ~w_diff + (GS_W+1)'(1);

    always_comb begin
        if (!w_wrap) begin
            w_mag = i_gidx;
        end else if (w_diff[GS_W]) begin
            w_mag = w_neg[MAG_W-1:0];
        end else begin
            w_mag = w_diff[MAG_W-1:0];
        end
    end

    // The two corners along this axis sit at |m| scaled, minus and plus h.
    assign w_s = {1'b0, w_mag, {FRAC_BITS{1'b0}}};
    assign w_h = {{(CMAG_W-HW_W){1'b0}}, i_half_width};

    assign o_axis.mag = w_mag;
    assign o_axis.chi = w_s + w_h;
    assign o_axis.clo = (w_s >= w_h) ? (w_s - w_h) : (w_h - w_s);

endmodule

FILE: sv/fshm_decide.sv
// Radius sums and the shell tests of all four modes.
module fshm_decide (
    input  fshm_pkg::t_stage2          i_s2,
    input  fshm_pkg::t_mode            i_mode,
    output logic                       o_sel,
    output logic [fshm_pkg::OUT_W-1:0] o_smin,
    output logic [fshm_pkg::OUT_W-1:0] o_smax
);
    import fshm_pkg::*;

    logic [MSUM_W-1:0] w_msum;
    logic [CMP_W-1:0]  w_m2;
    logic [CMP_W-1:0]  w_pmin;
    logic [CMP_W-1:0]  w_pmax;
    logic [CMP_W-1:0]  w_a;
    logic [CMP_W-1:0]  w_b;

    assign w_msum = MSUM_W'(i_s2.msq[0]) + MSUM_W'(i_s2.msq[1]) + MSUM_W'(i_s2.msq[2]);
    assign w_m2   = CMP_W'({w_msum, {(2*FRAC_BITS){1'b0}}});
    assign w_pmin = CMP_W'(i_s2.plo[0]) + CMP_W'(i_s2.plo[1]) + CMP_W'(i_s2.plo[2]);
    assign w_pmax = CMP_W'(i_s2.phi[0]) + CMP_W'(i_s2.phi[1]) + CMP_W'(i_s2.phi[2]);
    assign w_a    = CMP_W'(i_s2.bsq_a);
    assign w_b    = CMP_W'(i_s2.bsq_b);

    always_comb begin
        case (i_mode)
            MODE_CENTERED, MODE_BOUNDS: begin
                // A lower bound at or below zero always passes.
                o_sel = (w_m2 <= w_b) && (!i_s2.a_pos || (w_m2 >= w_a));
            end
            MODE_CORNER: begin
                o_sel = (w_pmin <= w_a) && (w_a <= w_pmax);
            end
            MODE_OVERLAP: begin
                o_sel = ((w_pmax >= w_b) && (w_pmin <= w_b)) ||
                        ((w_pmax <= w_b) && (w_pmin >= w_a)) ||
                        ((w_pmax >= w_a) && (w_pmin <= w_a));
            end
            default: begin
                o_sel = 1'b0;
            end
        endcase
    end

    assign o_smin = (|w_pmin[CMP_W-1:OUT_W]) ? {OUT_W{1'b1}} : w_pmin[OUT_W-1:0];
    assign o_smax = (|w_pmax[CMP_W-1:OUT_W]) ? {OUT_W{1'b1}} : w_pmax[OUT_W-1:0];

endmodule

FILE: sv/fshm_track.sv
// Running min and max of squared corner radii over selected cells.
module fshm_track (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic                       i_restart,
    input  logic                       i_sel,
    input  logic [fshm_pkg::OUT_W-1:0] i_smin,
    input  logic [fshm_pkg::OUT_W-1:0] i_smax,
    output logic [fshm_pkg::OUT_W-1:0] o_min,
    output logic [fshm_pkg::OUT_W-1:0] o_max
);
    import fshm_pkg::*;

    logic [OUT_W-1:0] r_min;
    logic [OUT_W-1:0] r_max;
    logic [OUT_W-1:0] n_min;
    logic [OUT_W-1:0] n_max;
    logic [OUT_W-1:0] w_base_min;
    logic [OUT_W-1:0] w_base_max;

    // A restart clears the trackers before the current cell is folded in.
    assign w_base_min = i_restart ? {OUT_W{1'b1}} : r_min;
    assign w_base_max = i_restart ? {OUT_W{1'b0}} : r_max;

    assign n_min = (i_sel && (i_smin < w_base_min)) ? i_smin : w_base_min;
    assign n_max = (i_sel && (i_smax > w_base_max)) ? i_smax : w_base_max;

    assign o_min = n_min;
    assign o_max = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= {OUT_W{1'b1}};
            r_max <= {OUT_W{1'b0}};
        end else if (i_take) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

endmodule

FILE: sv/fshm_checker.sv
// Port-level checks for the shell mask block and their binding to the top level.
`include "fourier_shell_mask_defines.svh"

module fshm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fshm_pkg::t_out_item o_out_data
);
    import fshm_pkg::*;

    logic w_out_stall;
    logic w_hit;
    logic w_trk_order;
    logic w_trk_clear;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_hit       = o_out_valid && o_out_data.in_shell;
    assign w_trk_order = o_out_data.min_corner_sq <= o_out_data.max_corner_sq;
    assign w_trk_clear = (o_out_data.min_corner_sq == {OUT_W{1'b1}}) &&
                         (o_out_data.max_corner_sq == {OUT_W{1'b0}});

    // A stalled result stays in place until it is taken.
    `FSHM_ASSERT_NXT(a_out_hold, w_out_stall, o_out_valid && $stable(o_out_data), "result not held")

    // With no result pending the pipeline can always take a request.
    `FSHM_ASSERT_IMP(a_in_free, !o_out_valid, o_in_ready, "request refused with empty output")

    // Trackers are either in their cleared state or ordered.
    `FSHM_ASSERT_IMP(a_trk_order, o_out_valid, w_trk_order || w_trk_clear, "tracker min above max")

    // A selected cell always leaves the trackers ordered.
    `FSHM_ASSERT_IMP(a_hit_order, w_hit, w_trk_order, "selected cell not tracked")

endmodule

bind fourier_shell_mask fshm_checker u_fshm_checker (.*);

FILE: tb/tb_fourier_shell_mask.sv
// Testbench for the k-space shell mask: directed and random cells checked against a predictor.
`timescale 1ns / 100ps

module tb_fourier_shell_mask;
    import fshm_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = CIDX_W'(7);
    localparam longint unsigned SAT_LIMIT = (64'd1 << OUT_W) - 1;
    localparam int unsigned MAX_GAP = 30;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_in_item            i_in_data   = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_item           o_out_data;
    logic                o_cfg_ready;

    // Register copies and tracker state of the predictor.
    t_mode               mode_q   = MODE_CENTERED;
    logic [GS_W-1:0]     grid_q   = GRID_RESET;
    logic [IDX_W-1:0]    slab_q   = '0;
    logic [RAD_W-1:0]    center_q = '0;
    logic [HW_W-1:0]     hw_q     = HW_RESET;
    logic [RAD_W-1:0]    low_q    = '0;
    logic [RAD_W-1:0]    high_q   = '0;
    logic [OUT_W-1:0]    min_track = '1;
    logic [OUT_W-1:0]    max_track = '0;

    t_out_item           pending_masks[$];
    t_out_item           oldest_mask;
    int unsigned         mismatch_count = 0;
    int unsigned         src_idle_pct   = 23;
    int unsigned         sink_idle_pct  = 86;

    fourier_shell_mask uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint wrap_freq(longint unsigned g);
        longint unsigned half;
        half = grid_q >> 1;
        if (g < half) begin
            return longint'(g);
        end
        return longint'(g) - longint'(grid_q);
    endfunction

    function automatic longint unsigned square_mag(longint v);
        longint unsigned a;
        a = (v < 0) ? -v : v;
        return a * a;
    endfunction

    // Smaller and larger square of the two corner offsets along one axis.
    function automatic void corner_span(input longint v, output longint unsigned lo,
                                        output longint unsigned hi);
        longint s;
        longint h;
        longint unsigned a;
        longint unsigned b;
        h = hw_q;
        s = v * (1 << FRAC_BITS);
        a = square_mag(s - h);
        b = square_mag(s + h);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
    endfunction

    function automatic bit radius_within(longint lo, longint hi, longint unsigned m2);
        if (hi < 0) begin
            return 1'b0;
        end
        if (m2 > square_mag(hi)) begin
            return 1'b0;
        end
        if (lo > 0 && m2 < square_mag(lo)) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_out_item shell_mask_of(t_in_item grid_pt);
        longint mx, my, mz, c, h, lb, hb;
        longint unsigned m2, l0, h0, l1, h1, l2, h2, pmin, pmax;
        longint unsigned cu, c2, lbu, hbu, lb2, hb2, smin, smax;
        bit sel;
        t_out_item res;
        mx = wrap_freq(longint'(grid_pt.x_local) + longint'(slab_q));
        my = wrap_freq(longint'(grid_pt.y_index));
        mz = wrap_freq(longint'(grid_pt.z_index));
        m2 = (square_mag(mx) + square_mag(my) + square_mag(mz)) << (2 * FRAC_BITS);
        c = center_q;
        h = hw_q;
        lb = low_q;
        hb = high_q;
        if (grid_pt.restart) begin
            min_track = '1;
            max_track = '0;
        end
        corner_span(mx, l0, h0);
        corner_span(my, l1, h1);
        corner_span(mz, l2, h2);
        pmin = l0 + l1 + l2;
        pmax = h0 + h1 + h2;
        case (mode_q)
            MODE_CENTERED: sel = radius_within(c - h, c + h, m2);
            MODE_BOUNDS:   sel = radius_within(lb - h, hb + h, m2);
            MODE_CORNER: begin
                cu = center_q;
                c2 = cu * cu;
                sel = (pmin <= c2) && (c2 <= pmax);
            end
            default: begin
                lbu = low_q;
                hbu = high_q;
                lb2 = lbu * lbu;
                hb2 = hbu * hbu;
                sel = (pmax >= hb2 && pmin <= hb2) || (pmax <= hb2 && pmin >= lb2) ||
                      (pmax >= lb2 && pmin <= lb2);
            end
        endcase
        if (sel) begin
            smin = (pmin > SAT_LIMIT) ? SAT_LIMIT : pmin;
            smax = (pmax > SAT_LIMIT) ? SAT_LIMIT : pmax;
            if (smin < min_track) begin
                min_track = smin[OUT_W-1:0];
            end
            if (smax > max_track) begin
                max_track = smax[OUT_W-1:0];
            end
        end
        res.in_shell      = sel;
        res.min_corner_sq = min_track;
        res.max_corner_sq = max_track;
        return res;
    endfunction

    // Sends one cell request; valid stays high afterwards unless a gap follows.
    task automatic send_cell(input int unsigned x, input int unsigned y,
                             input int unsigned z, input bit restart);
        t_in_item grid_pt;
        int unsigned gap;
        grid_pt.x_local = IDX_W'(x);
        grid_pt.y_index = IDX_W'(y);
        grid_pt.z_index = IDX_W'(z);
        grid_pt.restart = restart;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= grid_pt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_masks.push_back(shell_mask_of(grid_pt));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_masks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:         mode_q   = t_mode'(data[1:0]);
            CFG_GRID_SIZE:    grid_q   = data[GS_W-1:0];
            CFG_SLAB_START:   slab_q   = data[IDX_W-1:0];
            CFG_SHELL_CENTER: center_q = data[RAD_W-1:0];
            CFG_HALF_WIDTH:   hw_q     = data[HW_W-1:0];
            CFG_LOW_BOUND:    low_q    = data[RAD_W-1:0];
            CFG_HIGH_BOUND:   high_q   = data[RAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input t_mode m, input int unsigned grid,
                                    input int unsigned slab, input int unsigned center,
                                    input int unsigned hw, input int unsigned low,
                                    input int unsigned high);
        wait_idle();
        write_reg(CFG_MODE, CFG_W'(m));
        write_reg(CFG_GRID_SIZE, CFG_W'(grid));
        write_reg(CFG_SLAB_START, CFG_W'(slab));
        write_reg(CFG_SHELL_CENTER, CFG_W'(center));
        write_reg(CFG_HALF_WIDTH, CFG_W'(hw));
        write_reg(CFG_LOW_BOUND, CFG_W'(low));
        write_reg(CFG_HIGH_BOUND, CFG_W'(high));
        i_cfg_valid <= 1'b0;
    endtask

    // Reset values: centered shell of radius zero, so only cells near the origin pass.
    task automatic test_reset_state();
        send_cell(0, 0, 0, 1'b0);
        send_cell(1023, 1023, 1023, 1'b0);
        send_cell(128, 127, 255, 1'b1);
    endtask

    task automatic test_index_wrap();
        // A zero grid size never wraps, which gives the largest corner radii.
        program_settings(MODE_CENTERED, 0, 1023, 262143, 65535, 0, 0);
        send_cell(1023, 1023, 1023, 1'b1);
        send_cell(0, 512, 1, 1'b0);
        program_settings(MODE_OVERLAP, 2047, 1023, 0, 65535, 0, 262143);
        send_cell(1023, 1023, 1023, 1'b0);
        program_settings(MODE_CENTERED, 5, 3, 2 * 256, 256, 0, 0);
        send_cell(1, 2, 3, 1'b0);
        send_cell(4, 0, 1023, 1'b0);
        program_settings(MODE_CORNER, 1024, 0, 600 * 256, 128, 0, 0);
        send_cell(511, 512, 1023, 1'b0);
        program_settings(MODE_BOUNDS, 2, 0, 0, 0, 0, 1 * 256);
        send_cell(0, 1, 1, 1'b1);
    endtask

    task automatic test_each_mode();
        program_settings(MODE_CENTERED, 16, 0, 5 * 256, 128, 0, 0);
        send_cell(3, 4, 0, 1'b1);
        send_cell(8, 8, 8, 1'b0);
        program_settings(MODE_BOUNDS, 16, 0, 0, 128, 3 * 256, 6 * 256);
        send_cell(4, 4, 0, 1'b1);
        send_cell(15, 0, 0, 1'b0);
        // Crossed bounds: the upper limit lies below the lower one.
        program_settings(MODE_BOUNDS, 16, 0, 0, 128, 10 * 256, 2 * 256);
        send_cell(0, 2, 0, 1'b0);
        // Lower limit below zero always passes its test.
        program_settings(MODE_BOUNDS, 16, 0, 0, 128, 0, 0);
        send_cell(0, 0, 0, 1'b0);
        program_settings(MODE_OVERLAP, 16, 0, 0, 128, 2 * 256, 4 * 256);
        send_cell(2, 2, 2, 1'b1);
        send_cell(7, 7, 7, 1'b0);
        // Upper data bits of a mode write are dropped; an unused index changes nothing.
        wait_idle();
        write_reg(CFG_MODE, {16'hFFFF, MODE_CORNER});
        write_reg(CFG_UNUSED, CFG_W'($urandom_range(262143)));
        write_reg(CFG_SHELL_CENTER, CFG_W'(5 * 256));
        i_cfg_valid <= 1'b0;
        send_cell(3, 4, 0, 1'b1);
        send_cell(0, 0, 1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned g, span, reach, slab, center, hw, low, high;
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 86 : 0;
            sink_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 23 : 0;
            for (int s = 0; s < 5; s++) begin
                case ($urandom_range(9))
                    7:       g = 2 * $urandom_range(33, 512);
                    8:       g = $urandom_range(2047);
                    9:       g = 1024;
                    default: g = 2 * $urandom_range(1, 32);
                endcase
                span  = (g < 2 || g > 1024) ? 1024 : g;
                reach = (span * 222 + 256 > 262143) ? 262143 : span * 222 + 256;
                slab  = ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                 : $urandom_range(span - 1);
                center = $urandom_range(reach);
                hw     = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(768);
                low    = $urandom_range(reach);
                high   = ($urandom_range(5) == 0) ? $urandom_range(reach)
                                                  : low + $urandom_range(4 * 256);
                if (high > 262143) begin
                    high = 262143;
                end
                program_settings(t_mode'(s % 4), g, slab, center, hw, low, high);
                repeat (110) begin
                    send_cell(($urandom_range(9) == 0) ? $urandom_range(1023)
                                                       : $urandom_range(span - 1),
                              ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                       : $urandom_range(span - 1),
                              ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                       : $urandom_range(span - 1),
                              $urandom_range(19) == 0);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (pending_masks.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    oldest_mask = pending_masks.pop_front();
                    if (o_out_data.in_shell !== oldest_mask.in_shell) begin
                        $display("%0t: in_shell expected %0d actual %0d", $time,
                                 oldest_mask.in_shell, o_out_data.in_shell);
                        mismatch_count++;
                    end
                    if (o_out_data.min_corner_sq !== oldest_mask.min_corner_sq) begin
                        $display("%0t: min_corner_sq expected %h actual %h", $time,
                                 oldest_mask.min_corner_sq, o_out_data.min_corner_sq);
                        mismatch_count++;
                    end
                    if (o_out_data.max_corner_sq !== oldest_mask.max_corner_sq) begin
                        $display("%0t: max_corner_sq expected %h actual %h", $time,
                                 oldest_mask.max_corner_sq, o_out_data.max_corner_sq);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_index_wrap();
        test_each_mode();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
